// ===== hw/rtl/rapq_pkg.sv =====
package rapq_pkg;

    localparam int MAX_POSITIONS = 1024;
    localparam int TREE_NODES    = 4096;
    localparam int STACK_DEPTH   = 16;

    localparam int POS_W   = $clog2(MAX_POSITIONS);
    localparam int SIZE_W  = POS_W + 1;
    localparam int ADDR_W  = $clog2(TREE_NODES);
    localparam int NODE_W  = ADDR_W + 1;
    localparam int VALUE_W = 31;
    localparam int WORD_W  = 32;
    localparam int SP_W    = $clog2(STACK_DEPTH) + 1;

    localparam logic [WORD_W-1:0] INIT_WORD  = 32'h7FFF_FFFF;
    localparam logic [WORD_W-1:0] MIXED_WORD = 32'h8000_0000;
    localparam logic [WORD_W-1:0] QUERY_MISS = 32'hFFFF_FFFF;
    localparam logic [NODE_W-1:0] ROOT_NODE  = NODE_W'(1);

    localparam logic OP_ASSIGN = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    typedef struct packed {
        logic [POS_W-1:0] mid;
        logic             covered;
        logic             disjoint;
        logic             leaf;
        logic             go_left;
    } span_t;

    typedef struct packed {
        logic [NODE_W-1:0] node;
        logic [POS_W-1:0]  lo;
        logic [POS_W-1:0]  hi;
    } frame_t;

endpackage

// ===== hw/rtl/rapq_span_unit.sv =====
module rapq_span_unit
    import rapq_pkg::*;
(
    input  logic [POS_W-1:0] lo,
    input  logic [POS_W-1:0] hi,
    input  logic [POS_W-1:0] first,
    input  logic [POS_W-1:0] last,
    input  logic [POS_W-1:0] key,
    output span_t            span
);

    logic [POS_W:0] span_sum;

    assign span_sum      = {1'b0, lo} + {1'b0, hi};
    assign span.mid      = span_sum[POS_W:1];
    assign span.covered  = (first <= lo) && (hi <= last);
    assign span.disjoint = (last < lo) || (first > hi);
    assign span.leaf     = (lo >= hi);
    assign span.go_left  = (key <= span_sum[POS_W:1]);

endmodule

// ===== hw/rtl/range_assign_point_query_tree.sv =====
// Segment tree over up to 1024 positions with range assign and point query. A query
// walks from the root, one node memory read per tree level; a query outside the
// used size answers -1. An update visits nodes depth first through the node memory
// and one shared span compare unit: a skipped or fully covered node passes through
// the visit and pop states, a partly covered node that is split through the visit
// state, the read state that writes the left child, the right-child write and the
// node write, and a partly covered node that is already mixed through the visit
// and read states. The block takes no new request until the current one is done,
// but a finished query result waits in its own output register. Reset and any
// write of positions_in_use return the tree to all 2147483647 at once with no
// clearing pass: only the root is marked fresh, and every other node is rewritten
// before it can be read.
module range_assign_point_query_tree
    import rapq_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [10:0] cfg_wdata,     // positions_in_use
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,       // range_first, range_last, new_value, query_position
    input  logic        s_tuser,       // operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata        // query_result
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_VISIT  = 4'd1;
    localparam logic [3:0] S_UREAD  = 4'd2;
    localparam logic [3:0] S_PUSH_R = 4'd3;
    localparam logic [3:0] S_PUSH_N = 4'd4;
    localparam logic [3:0] S_POP    = 4'd5;
    localparam logic [3:0] S_QREAD  = 4'd6;
    localparam logic [3:0] S_DONE   = 4'd7;

    logic [3:0]         state_reg, state_next;
    logic [SIZE_W-1:0]  positions_reg;
    logic               root_valid_reg;
    logic [NODE_W-1:0]  node_reg, node_next;
    logic [POS_W-1:0]   lo_reg, lo_next;
    logic [POS_W-1:0]   hi_reg, hi_next;
    logic [POS_W-1:0]   first_reg, first_next;
    logic [POS_W-1:0]   last_reg, last_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [VALUE_W-1:0] value_reg, value_next;
    logic [WORD_W-1:0]  held_reg, held_next;
    logic [WORD_W-1:0]  result_reg, result_next;
    logic [SP_W-1:0]    sp_reg, sp_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [WORD_W-1:0]  m_tdata_reg, m_tdata_next;

    logic [WORD_W-1:0]  node_mem [TREE_NODES];
    logic [WORD_W-1:0]  rd_data_reg;
    logic               rd_root_reg;
    logic [WORD_W-1:0]  rd_word;
    logic               mem_we, mem_re;
    logic [ADDR_W-1:0]  mem_wa, mem_ra;
    logic [WORD_W-1:0]  mem_wd;

    frame_t             stack_mem [STACK_DEPTH];
    logic               push_en;
    frame_t             push_frame;
    frame_t             top_frame;
    logic [SP_W-1:0]    sp_dec;

    logic [SIZE_W-1:0]  used_size;
    logic [POS_W-1:0]   in_first, in_last, in_pos;
    logic [VALUE_W-1:0] in_value;
    logic [NODE_W-1:0]  left_node, right_node, next_node;
    span_t              span;

    assign in_first = s_tdata[9:0];
    assign in_last  = s_tdata[19:10];
    assign in_value = s_tdata[50:20];
    assign in_pos   = s_tdata[60:51];

    assign used_size = (positions_reg > SIZE_W'(MAX_POSITIONS)) ? SIZE_W'(MAX_POSITIONS)
                                                                 : positions_reg;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign rd_word    = (rd_root_reg && !root_valid_reg) ? INIT_WORD : rd_data_reg;
    assign left_node  = {node_reg[NODE_W-2:0], 1'b0};
    assign right_node = {node_reg[NODE_W-2:0], 1'b1};
    assign next_node  = span.go_left ? left_node : right_node;
    assign sp_dec     = sp_reg - SP_W'(1);
    assign top_frame  = stack_mem[sp_dec[SP_W-2:0]];

    rapq_span_unit u_span (
        .lo    (lo_reg),
        .hi    (hi_reg),
        .first (first_reg),
        .last  (last_reg),
        .key   (pos_reg),
        .span  (span)
    );

    always_comb begin
        state_next    = state_reg;
        node_next     = node_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        first_next    = first_reg;
        last_next     = last_reg;
        pos_next      = pos_reg;
        value_next    = value_reg;
        held_next     = held_reg;
        result_next   = result_reg;
        sp_next       = sp_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        mem_we        = 1'b0;
        mem_wa        = node_reg[ADDR_W-1:0];
        mem_wd        = held_reg;
        mem_re        = 1'b0;
        mem_ra        = node_reg[ADDR_W-1:0];
        push_en       = 1'b0;
        push_frame    = '{node: right_node, lo: span.mid + POS_W'(1), hi: hi_reg};

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    first_next = in_first;
                    last_next  = in_last;
                    pos_next   = in_pos;
                    value_next = in_value;
                    node_next  = ROOT_NODE;
                    lo_next    = '0;
                    hi_next    = POS_W'(used_size - SIZE_W'(1));
                    sp_next    = '0;
                    if (s_tuser == OP_QUERY) begin
                        if (used_size == '0 || {1'b0, in_pos} >= used_size) begin
                            result_next = QUERY_MISS;
                            state_next  = S_DONE;
                        end else begin
                            mem_re     = 1'b1;
                            mem_ra     = ROOT_NODE[ADDR_W-1:0];
                            state_next = S_QREAD;
                        end
                    end else if (used_size != '0 && in_first <= in_last &&
                                 {1'b0, in_first} < used_size) begin
                        state_next = S_VISIT;
                    end
                end
            end
            S_VISIT: begin
                if (node_reg[NODE_W-1] || span.disjoint) begin
                    state_next = S_POP;
                end else if (span.covered) begin
                    mem_we     = 1'b1;
                    mem_wd     = {1'b0, value_reg};
                    state_next = S_POP;
                end else begin
                    mem_re     = 1'b1;
                    state_next = S_UREAD;
                end
            end
            S_UREAD: begin
                held_next = rd_word;
                if (!rd_word[WORD_W-1] && node_reg < NODE_W'(TREE_NODES / 2)) begin
                    mem_we     = 1'b1;
                    mem_wa     = left_node[ADDR_W-1:0];
                    mem_wd     = rd_word;
                    state_next = S_PUSH_R;
                end else begin
                    push_en    = 1'b1;
                    sp_next    = sp_reg + SP_W'(1);
                    node_next  = left_node;
                    hi_next    = span.mid;
                    state_next = S_VISIT;
                end
            end
            S_PUSH_R: begin
                mem_we     = 1'b1;
                mem_wa     = right_node[ADDR_W-1:0];
                mem_wd     = held_reg;
                state_next = S_PUSH_N;
            end
            S_PUSH_N: begin
                mem_we     = 1'b1;
                mem_wd     = MIXED_WORD;
                push_en    = 1'b1;
                sp_next    = sp_reg + SP_W'(1);
                node_next  = left_node;
                hi_next    = span.mid;
                state_next = S_VISIT;
            end
            S_POP: begin
                if (sp_reg == '0) begin
                    state_next = S_IDLE;
                end else begin
                    node_next  = top_frame.node;
                    lo_next    = top_frame.lo;
                    hi_next    = top_frame.hi;
                    sp_next    = sp_dec;
                    state_next = S_VISIT;
                end
            end
            S_QREAD: begin
                if (!rd_word[WORD_W-1] || span.leaf || next_node[NODE_W-1]) begin
                    result_next = {1'b0, rd_word[VALUE_W-1:0]};
                    state_next  = S_DONE;
                end else begin
                    mem_re    = 1'b1;
                    mem_ra    = next_node[ADDR_W-1:0];
                    node_next = next_node;
                    if (span.go_left) begin
                        hi_next = span.mid;
                    end else begin
                        lo_next = span.mid + POS_W'(1);
                    end
                end
            end
            S_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = result_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            sp_reg         <= '0;
            m_tvalid_reg   <= 1'b0;
            positions_reg  <= SIZE_W'(MAX_POSITIONS);
            root_valid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            sp_reg       <= sp_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_we) begin
                positions_reg  <= cfg_wdata;
                root_valid_reg <= 1'b0;
            end else if (mem_we && mem_wa == ROOT_NODE[ADDR_W-1:0]) begin
                root_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        node_reg    <= node_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        first_reg   <= first_next;
        last_reg    <= last_next;
        pos_reg     <= pos_next;
        value_reg   <= value_next;
        held_reg    <= held_next;
        result_reg  <= result_next;
        m_tdata_reg <= m_tdata_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            node_mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            rd_data_reg <= node_mem[mem_ra];
            rd_root_reg <= (mem_ra == ROOT_NODE[ADDR_W-1:0]);
        end
    end

    always_ff @(posedge aclk) begin
        if (push_en) begin
            stack_mem[sp_reg[SP_W-2:0]] <= push_frame;
        end
    end

endmodule

// ===== hw/rtl/rapq_checker.sv =====
module rapq_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    // stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // a result is either a stored value or the miss code
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (!m_tdata[31] || m_tdata == 32'hFFFF_FFFF))
        else $error("result out of range");

    // an accepted query keeps the block busy in the cycle after it
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser |=> !s_tready)
        else $error("query accepted without busy cycle");

    // a new result only comes out of a busy cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result without pending query");

    // idle and empty right after reset
    assert property (@(posedge aclk)
        $past(!aresetn) && aresetn |-> s_tready && !m_tvalid)
        else $error("not idle after reset");

endmodule

bind range_assign_point_query_tree rapq_checker u_rapq_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== dv/tb_range_assign_point_query_tree.sv =====
module tb_range_assign_point_query_tree
    import rapq_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE_CYCLES    = 200;
    localparam int HOLD_CYCLES      = 400;
    localparam int IDLE_LIMIT       = 3000;
    localparam int RANDOM_PER_PHASE = 75;
    localparam int PHASES           = 6;
    localparam int DIR_ROWS         = 29;

    typedef enum logic {ROW_REQUEST, ROW_CONFIG} row_kind_t;

    typedef struct {
        row_kind_t          kind;
        logic               op;
        logic [POS_W-1:0]   first;
        logic [POS_W-1:0]   last;
        logic [VALUE_W-1:0] value;
        logic [POS_W-1:0]   pos;
        bit                 fixed;
        logic [WORD_W-1:0]  answer;
    } dir_row_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [10:0] cfg_wdata = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata   = '0;
    logic        s_tuser   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;

    logic [VALUE_W-1:0] shadow_positions [MAX_POSITIONS];
    int                 shadow_size;
    logic [WORD_W-1:0]  pending_answers [$];
    int                 mismatch_count = 0;
    int                 idle_cycles = 0;
    bit                 hold_request = 0;
    bit                 burst_mode = 0;

    dir_row_t directed_rows [DIR_ROWS] = '{
        '{ROW_REQUEST, OP_QUERY,  0,    0,    0,            0,    1, INIT_WORD},
        '{ROW_REQUEST, OP_QUERY,  1023, 1023, 31'h7FFFFFFF, 1023, 1, INIT_WORD},
        '{ROW_REQUEST, OP_ASSIGN, 0,    1023, 0,            0,    0, 0},
        '{ROW_REQUEST, OP_QUERY,  1023, 0,    31'h7FFFFFFF, 512,  1, 0},
        '{ROW_REQUEST, OP_ASSIGN, 5,    3,    99,           0,    0, 0},
        '{ROW_REQUEST, OP_QUERY,  0,    0,    0,            4,    1, 0},
        '{ROW_REQUEST, OP_ASSIGN, 1023, 1023, 31'h7FFFFFFF, 1023, 0, 0},
        '{ROW_REQUEST, OP_QUERY,  0,    0,    0,            1023, 1, INIT_WORD},
        '{ROW_REQUEST, OP_ASSIGN, 100,  200,  31'h2AAAAAAA, 0,    0, 0},
        '{ROW_REQUEST, OP_QUERY,  0,    0,    0,            100,  0, 0},
        '{ROW_REQUEST, OP_QUERY,  0,    0,    0,            200,  0, 0},
        '{ROW_REQUEST, OP_QUERY,  0,    0,    0,            201,  1, 0},
        '{ROW_REQUEST, OP_ASSIGN, 300,  700,  12345,        0,    0, 0},
        '{ROW_REQUEST, OP_ASSIGN, 400,  500,  777,          0,    0, 0},
        '{ROW_REQUEST, OP_QUERY,  0,    0,    0,            450,  0, 0},
        '{ROW_REQUEST, OP_QUERY,  0,    0,    0,            399,  0, 0},
        '{ROW_CONFIG,  OP_ASSIGN, 0,    0,    0,            0,    0, 0},
        '{ROW_REQUEST, OP_QUERY,  0,    0,    0,            0,    1, QUERY_MISS},
        '{ROW_REQUEST, OP_ASSIGN, 0,    10,   5,            0,    0, 0},
        '{ROW_REQUEST, OP_QUERY,  0,    0,    0,            1023, 1, QUERY_MISS},
        '{ROW_CONFIG,  OP_ASSIGN, 0,    0,    2047,         0,    0, 0},
        '{ROW_REQUEST, OP_QUERY,  0,    0,    0,            1023, 1, INIT_WORD},
        '{ROW_REQUEST, OP_ASSIGN, 1000, 1023, 1,            0,    0, 0},
        '{ROW_REQUEST, OP_QUERY,  0,    0,    0,            1023, 0, 0},
        '{ROW_CONFIG,  OP_ASSIGN, 0,    0,    1,            0,    0, 0},
        '{ROW_REQUEST, OP_QUERY,  0,    0,    0,            1,    1, QUERY_MISS},
        '{ROW_REQUEST, OP_QUERY,  0,    0,    0,            0,    1, INIT_WORD},
        '{ROW_REQUEST, OP_ASSIGN, 0,    1023, 42,           0,    0, 0},
        '{ROW_REQUEST, OP_QUERY,  0,    0,    0,            0,    0, 0}
    };

    range_assign_point_query_tree dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #2 aclk = ~aclk;

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic void clear_shadow(int size);
        shadow_size = (size > MAX_POSITIONS) ? MAX_POSITIONS : size;
        foreach (shadow_positions[i]) shadow_positions[i] = INIT_WORD[VALUE_W-1:0];
    endfunction

    // applies one request to the flat copy of the positions, returns the query answer
    function automatic logic [WORD_W-1:0] apply_to_positions(logic op,
            logic [POS_W-1:0] first, logic [POS_W-1:0] last,
            logic [VALUE_W-1:0] value, logic [POS_W-1:0] pos);
        int top;
        logic [WORD_W-1:0] answer;
        answer = QUERY_MISS;
        if (op == OP_ASSIGN) begin
            if (shadow_size != 0 && int'(first) <= int'(last) && int'(first) < shadow_size) begin
                top = (int'(last) < shadow_size) ? int'(last) : shadow_size - 1;
                for (int p = int'(first); p <= top; p++) shadow_positions[p] = value;
            end
        end else if (int'(pos) < shadow_size) begin
            answer = {1'b0, shadow_positions[pos]};
        end
        return answer;
    endfunction

    task automatic send_request(logic op, logic [POS_W-1:0] first, logic [POS_W-1:0] last,
            logic [VALUE_W-1:0] value, logic [POS_W-1:0] pos, bit fixed,
            logic [WORD_W-1:0] answer);
        int gap;
        logic [WORD_W-1:0] predicted;
        gap = burst_mode ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {3'b000, pos, value, last, first};
        do @(posedge aclk); while (!s_tready);
        predicted = apply_to_positions(op, first, last, value, pos);
        if (op == OP_QUERY) pending_answers.push_back(fixed ? answer : predicted);
    endtask

    task automatic write_positions(logic [10:0] size);
        s_tvalid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge aclk);
        // an update gives no result, so let a last one run out
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= size;
        @(posedge aclk);
        cfg_we <= 1'b0;
        clear_shadow(int'(size));
    endtask

    task automatic send_random_request();
        int span;
        int first_i;
        int last_i;
        logic [VALUE_W-1:0] value;
        logic [POS_W-1:0] pos;
        span = (shadow_size == 0) ? MAX_POSITIONS : shadow_size;
        first_i = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023)
                                              : $urandom_range(0, span - 1);
        case ($urandom_range(0, 3))
            0: last_i = first_i;
            1: last_i = (first_i + $urandom_range(0, 15) > 1023) ? 1023
                                                               : first_i + $urandom_range(0, 15);
            2: last_i = $urandom_range(first_i, 1023);
            default: last_i = $urandom_range(0, 1023);
        endcase
        case ($urandom_range(0, 7))
            0: value = '0;
            1: value = '1;
            default: value = VALUE_W'($urandom());
        endcase
        pos = ($urandom_range(0, 3) == 0) ? POS_W'($urandom_range(0, 1023))
                                          : POS_W'($urandom_range(0, span - 1));
        send_request(($urandom_range(0, 99) < 55) ? OP_QUERY : OP_ASSIGN,
                     POS_W'(first_i), POS_W'(last_i), value, pos, 0, '0);
    endtask

    initial begin : result_side
        int gap;
        logic [WORD_W-1:0] want;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (hold_request) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_request = 0;
            end
            gap = burst_mode ? 0 : $urandom_range(0, 8);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            if (pending_answers.size() == 0) begin
                $error("query_result expected none got %0d", $signed(m_tdata));
                mismatch_count++;
            end else begin
                want = pending_answers.pop_front();
                if (m_tdata !== want) begin
                    $error("query_result expected %0d got %0d", $signed(want), $signed(m_tdata));
                    mismatch_count++;
                end
            end
        end
    end

    initial begin : request_side
        int phase_sizes [PHASES];
        clear_shadow(MAX_POSITIONS);
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_CONFIG) begin
                write_positions(directed_rows[i].value[10:0]);
            end else begin
                send_request(directed_rows[i].op, directed_rows[i].first,
                             directed_rows[i].last, directed_rows[i].value,
                             directed_rows[i].pos, directed_rows[i].fixed,
                             directed_rows[i].answer);
            end
        end

        phase_sizes = '{1024, 2, 1000, 5, 2047, 1};
        phase_sizes[1] = $urandom_range(2, 1023);
        for (int ph = 0; ph < PHASES; ph++) begin
            write_positions(11'(phase_sizes[ph]));
            burst_mode = (ph % 3 == 2);
            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                // receiver backs off while queries keep coming
                if (ph == 0 && n == RANDOM_PER_PHASE / 2) begin
                    hold_request = 1;
                    for (int k = 0; k < 24; k++) begin
                        send_request(OP_QUERY, POS_W'($urandom()), POS_W'($urandom()),
                                     VALUE_W'($urandom()), POS_W'($urandom()), 0, '0);
                    end
                end
                send_random_request();
            end
        end
        burst_mode = 0;

        s_tvalid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/rapq_pkg.sv
hw/rtl/rapq_span_unit.sv
hw/rtl/range_assign_point_query_tree.sv
hw/rtl/rapq_checker.sv
dv/tb_range_assign_point_query_tree.sv
